// ----- rtl/cmt_pkg.sv -----
// ----------------------------------------------------------------------------
// Calibrator move tracker package
// Shared item types, state codes and the report debounce function.
// ----------------------------------------------------------------------------
package cmt_pkg;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_FRAME   = 1'b1;

    localparam logic CFG_MIN_WAIT = 1'b0;
    localparam logic CFG_MAX_WAIT = 1'b1;

    localparam logic [2:0] REP_UNKNOWN = 3'd0;
    localparam logic [2:0] REP_MOVING  = 3'd1;
    localparam logic [2:0] REP_SKY     = 3'd2;
    localparam logic [2:0] REP_AMBIENT = 3'd3;
    localparam logic [2:0] REP_PARTIAL = 3'd4;
    localparam logic [2:0] REP_HOT     = 3'd5;
    localparam logic [2:0] REP_STUCK   = 3'd6;
    localparam logic [2:0] NO_TARGET   = 3'd7;

    localparam logic [2:0] COMMON_ERROR  = 3'd0;
    localparam logic [2:0] COMMON_MOVING = 3'd1;

    localparam logic [2:0] POSITION_BASE = REP_SKY;

    localparam logic [4:0] FRAMES_MAX     = 5'd31;
    localparam logic [4:0] MIN_WAIT_RESET = 5'd2;
    localparam logic [4:0] MAX_WAIT_RESET = 5'd20;

    typedef struct packed {
        logic        cmd;
        logic [1:0]  requested_position;
        logic [31:0] sequence_no;
        logic        seq_to_receiver;
        logic [2:0]  reported_state;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  common_state;
        logic        state_acquired;
        logic [31:0] cal_sequence;
        logic        tune_seq_valid;
        logic [31:0] tune_sequence;
    } out_item_t;

    // A position counts only when it repeats the previous report.
    function automatic logic [2:0] debounce(input logic [2:0] rep, input logic [2:0] prev);
        logic [2:0] res;
        case (rep) inside
            REP_MOVING:                               res = COMMON_MOVING;
            REP_SKY, REP_AMBIENT, REP_PARTIAL, REP_HOT: res = (prev == rep) ? rep : COMMON_MOVING;
            default:                                  res = COMMON_ERROR;
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/cmt_in_if.sv -----
// ----------------------------------------------------------------------------
// Calibrator move tracker input channel
// Valid/ready channel carrying one request or frame item.
// ----------------------------------------------------------------------------
interface cmt_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [1:0]  requested_position;
    logic [31:0] sequence_no;
    logic        seq_to_receiver;
    logic [2:0]  reported_state;

    modport source (
        output valid, cmd, requested_position, sequence_no, seq_to_receiver, reported_state,
        input  ready
    );
    modport sink (
        input  valid, cmd, requested_position, sequence_no, seq_to_receiver, reported_state,
        output ready
    );
endinterface

// ----- rtl/cmt_out_if.sv -----
// ----------------------------------------------------------------------------
// Calibrator move tracker output channel
// Valid/ready channel carrying one frame result.
// ----------------------------------------------------------------------------
interface cmt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  common_state;
    logic        state_acquired;
    logic [31:0] cal_sequence;
    logic        tune_seq_valid;
    logic [31:0] tune_sequence;

    modport source (
        output valid, common_state, state_acquired, cal_sequence, tune_seq_valid,
               tune_sequence,
        input  ready
    );
    modport sink (
        input  valid, common_state, state_acquired, cal_sequence, tune_seq_valid,
               tune_sequence,
        output ready
    );
endinterface

// ----- rtl/cmt_tracker.sv -----
// ----------------------------------------------------------------------------
// Calibrator move tracker state
// Holds the wait limits and the move state, and forms the frame result.
// ----------------------------------------------------------------------------
module cmt_tracker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_fire,
    input  cmt_pkg::in_item_t  item,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data,
    output cmt_pkg::out_item_t result
);

    logic [4:0]  min_wait_reg;
    logic [4:0]  max_wait_reg;
    logic        pending_reg;
    logic [4:0]  pending_frames_reg;
    logic [2:0]  target_state_reg;
    logic [31:0] pending_sequence_reg;
    logic        route_to_receiver_reg;
    logic [31:0] current_sequence_reg;
    logic [2:0]  last_report_reg;

    logic [4:0]  frames_next;
    logic        has_target;
    logic        target_hit;
    logic        complete;

    always_comb
    begin
        has_target  = (target_state_reg != cmt_pkg::NO_TARGET);
        target_hit  = has_target && (item.reported_state == target_state_reg);
        frames_next = (pending_frames_reg < cmt_pkg::FRAMES_MAX)
                    ? pending_frames_reg + 5'd1 : pending_frames_reg;
        complete    = pending_reg && (frames_next >= min_wait_reg) &&
                      (target_hit || (frames_next >= max_wait_reg));

        result.common_state   = cmt_pkg::debounce(item.reported_state, last_report_reg);
        result.state_acquired = target_hit && (last_report_reg == item.reported_state);
        result.cal_sequence   = (complete && !route_to_receiver_reg)
                              ? pending_sequence_reg : current_sequence_reg;
        result.tune_seq_valid = complete && route_to_receiver_reg;
        result.tune_sequence  = (complete && route_to_receiver_reg)
                              ? pending_sequence_reg : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_wait_reg          <= cmt_pkg::MIN_WAIT_RESET;
            max_wait_reg          <= cmt_pkg::MAX_WAIT_RESET;
            pending_reg           <= 1'b0;
            pending_frames_reg    <= 5'd0;
            target_state_reg      <= cmt_pkg::NO_TARGET;
            pending_sequence_reg  <= 32'd0;
            route_to_receiver_reg <= 1'b0;
            current_sequence_reg  <= 32'd0;
            last_report_reg       <= cmt_pkg::REP_UNKNOWN;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    cmt_pkg::CFG_MIN_WAIT: min_wait_reg <= cfg_data;
                    cmt_pkg::CFG_MAX_WAIT: max_wait_reg <= cfg_data;
                endcase
            end
            if (item_fire)
            begin
                if (item.cmd == cmt_pkg::CMD_REQUEST)
                begin
                    target_state_reg      <= {1'b0, item.requested_position}
                                           + cmt_pkg::POSITION_BASE;
                    pending_reg           <= 1'b1;
                    pending_frames_reg    <= 5'd0;
                    pending_sequence_reg  <= item.sequence_no;
                    route_to_receiver_reg <= item.seq_to_receiver;
                end
                else
                begin
                    last_report_reg <= item.reported_state;
                    if (complete)
                    begin
                        if (!route_to_receiver_reg)
                        begin
                            current_sequence_reg <= pending_sequence_reg;
                        end
                        pending_reg           <= 1'b0;
                        pending_frames_reg    <= 5'd0;
                        route_to_receiver_reg <= 1'b0;
                    end
                    else if (pending_reg)
                    begin
                        pending_frames_reg <= frames_next;
                    end
                end
            end
        end
    end

endmodule

// ----- rtl/calibrator_move_tracker_unit.sv -----
// Path: a frame request passes the input register and then the output register before it is shown on the output.
// Throughput: one request per cycle, requests of either kind, while the output is drained.
// Only frame requests give a result; position requests update the state alone.
// Reset: rst_n clears both pipeline stages and the move state, and loads the
// default wait limits of 2 and 20 frames.
// ----------------------------------------------------------------------------
// Calibrator move tracker top level
// Input register, tracker state and output register with valid/ready channels.
// ----------------------------------------------------------------------------
module calibrator_move_tracker_unit (
    input  logic        clk,
    input  logic        rst_n,
    cmt_in_if.sink      in_ch,
    cmt_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);

    logic               in_valid_reg;
    cmt_pkg::in_item_t  in_item_reg;
    logic               out_valid_reg;
    cmt_pkg::out_item_t out_item_reg;

    cmt_pkg::out_item_t result;
    logic               out_free;
    logic               proc_fire;
    logic               is_frame;

    assign is_frame    = (in_item_reg.cmd == cmt_pkg::CMD_FRAME);
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign proc_fire   = in_valid_reg && (!is_frame || out_free);
    assign in_ch.ready = !in_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_item_reg.cmd                <= in_ch.cmd;
            in_item_reg.requested_position <= in_ch.requested_position;
            in_item_reg.sequence_no        <= in_ch.sequence_no;
            in_item_reg.seq_to_receiver    <= in_ch.seq_to_receiver;
            in_item_reg.reported_state     <= in_ch.reported_state;
        end
    end

    cmt_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_fire (proc_fire),
        .item      (in_item_reg),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire && is_frame)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && is_frame)
        begin
            out_item_reg <= result;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.common_state   = out_item_reg.common_state;
    assign out_ch.state_acquired = out_item_reg.state_acquired;
    assign out_ch.cal_sequence   = out_item_reg.cal_sequence;
    assign out_ch.tune_seq_valid = out_item_reg.tune_seq_valid;
    assign out_ch.tune_sequence  = out_item_reg.tune_sequence;

endmodule
